[rtl/timestamped_union_find_top_defines.svh]
// assertion macros for the timestamped union-find block
`ifndef TIMESTAMPED_UNION_FIND_TOP_DEFINES_SVH
`define TIMESTAMPED_UNION_FIND_TOP_DEFINES_SVH
`ifndef SYNTH
`define TUF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TUF_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TUF_ASSERT(label, clk, rst, prop, msg)
`define TUF_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

[rtl/tuf_pkg.sv]
// shared constants, types and helpers of the timestamped union-find block
`default_nettype none
package tuf_pkg;
   localparam int NUM_VERTICES = 1024;
   localparam int NUM_FORESTS  = 64;
   localparam int STORE_DEPTH  = NUM_VERTICES * NUM_FORESTS;
   localparam int ADDR_W       = $clog2(STORE_DEPTH);
   localparam int VERTEX_W     = 10;
   localparam int FOREST_W     = 6;
   localparam int TIME_W       = 6;
   localparam int SIZE_W       = 11;
   localparam int STEP_W       = $clog2(NUM_VERTICES + 1);

   localparam logic MODE_UNION = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef logic [VERTEX_W-1:0] vertex_type;
   typedef logic [FOREST_W-1:0] forest_type;
   typedef logic [TIME_W-1:0]   stamp_type;
   typedef logic [SIZE_W-1:0]   size_type;
   typedef logic [STEP_W-1:0]   step_type;
   typedef logic [ADDR_W-1:0]   addr_type;

   typedef struct packed {
      vertex_type parent;
      stamp_type  stamp;
      size_type   size;
   } entry_type;

   typedef struct packed {
      logic      en;
      logic      we;
      addr_type  addr;
      entry_type wdata;
   } mem_req_type;

   typedef struct packed {
      logic       valid;
      vertex_type representative;
      logic       merged;
   } result_type;

   typedef struct packed {
      logic clearing;
      logic item_ready;
   } status_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND_A,
      ST_FIND_B,
      ST_SIZE_A,
      ST_SIZE_B,
      ST_LINK_SMALL,
      ST_QUERY,
      ST_DONE
   } state_type;

   function automatic addr_type slot(input forest_type f, input vertex_type v);
      return addr_type'(32'(f) * NUM_VERTICES + 32'(v));
   endfunction
endpackage
`default_nettype wire

[rtl/tuf_ram.sv]
// generic single-port synchronous ram with registered read
`default_nettype none
module tuf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

[rtl/tuf_engine.sv]
// sequencer: clearing pass, root finding, linking and windowed climb over the store
`default_nettype none
module tuf_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_mode,
   input  tuf_pkg::forest_type req_forest,
   input  tuf_pkg::vertex_type req_vertex_a,
   input  tuf_pkg::vertex_type req_vertex_b,
   input  tuf_pkg::stamp_type  req_time_stamp,
   input  logic                rsp_free,
   input  tuf_pkg::entry_type  mem_rdata,
   output tuf_pkg::mem_req_type mem_req,
   output tuf_pkg::result_type result,
   output tuf_pkg::status_type status
);
   import tuf_pkg::*;

   state_type  state_ff, state_in;
   forest_type forest_ff, forest_in;
   vertex_type vb_ff, vb_in;
   stamp_type  stamp_ff, stamp_in;
   vertex_type cur_ff, cur_in;
   step_type   steps_ff, steps_in;
   vertex_type ra_ff, ra_in;
   entry_type  word_a_ff, word_a_in;
   vertex_type big_ff, big_in;
   vertex_type small_ff, small_in;
   size_type   small_size_ff, small_size_in;
   vertex_type rep_ff, rep_in;
   logic       merged_ff, merged_in;
   vertex_type clr_v_ff, clr_v_in;
   forest_type clr_f_ff, clr_f_in;

   vertex_type p;
   logic       is_root;
   logic       stamp_ok;
   logic       go_on;
   logic       walk_done;
   step_type   step_next;
   vertex_type walk_end;
   logic       in_range;
   logic       a_small;
   entry_type  big_word;
   size_type   small_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_v_ff <= '0;
         clr_f_ff <= '0;
      end else begin
         state_ff <= state_in;
         clr_v_ff <= clr_v_in;
         clr_f_ff <= clr_f_in;
      end
   end

   always_ff @(posedge clock) begin
      forest_ff     <= forest_in;
      vb_ff         <= vb_in;
      stamp_ff      <= stamp_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      ra_ff         <= ra_in;
      word_a_ff     <= word_a_in;
      big_ff        <= big_in;
      small_ff      <= small_in;
      small_size_ff <= small_size_in;
      rep_ff        <= rep_in;
      merged_ff     <= merged_in;
   end

   // one climb step: stop at a root, at a query link stamped past the window, or at the step cap
   always_comb begin
      p         = mem_rdata.parent;
      is_root   = (p == cur_ff) || (32'(p) >= NUM_VERTICES);
      stamp_ok  = (state_ff != ST_QUERY) || (mem_rdata.stamp <= stamp_ff);
      go_on     = !is_root && stamp_ok;
      step_next = steps_ff + step_type'(1);
      walk_done = !go_on || (go_on && (32'(step_next) == NUM_VERTICES));
      walk_end  = go_on ? p : cur_ff;
      in_range  = (32'(req_forest) < NUM_FORESTS) && (32'(req_vertex_a) < NUM_VERTICES)
                  && ((req_mode == MODE_QUERY) || (32'(req_vertex_b) < NUM_VERTICES));
      a_small   = word_a_ff.size < mem_rdata.size;
      big_word  = a_small ? mem_rdata : word_a_ff;
      small_size = a_small ? word_a_ff.size : mem_rdata.size;
   end

   always_comb begin
      state_in      = state_ff;
      forest_in     = forest_ff;
      vb_in         = vb_ff;
      stamp_in      = stamp_ff;
      cur_in        = cur_ff;
      steps_in      = steps_ff;
      ra_in         = ra_ff;
      word_a_in     = word_a_ff;
      big_in        = big_ff;
      small_in      = small_ff;
      small_size_in = small_size_ff;
      rep_in        = rep_ff;
      merged_in     = merged_ff;
      clr_v_in      = clr_v_ff;
      clr_f_in      = clr_f_ff;
      mem_req       = '0;
      result        = '0;
      status        = '0;
      result.representative = rep_ff;
      result.merged         = merged_ff;

      case (state_ff)
         ST_CLEAR: begin
            status.clearing    = 1'b1;
            mem_req.en         = 1'b1;
            mem_req.we         = 1'b1;
            mem_req.addr       = slot(clr_f_ff, clr_v_ff);
            mem_req.wdata      = '{parent: clr_v_ff, stamp: stamp_type'(clr_f_ff),
                                   size: size_type'(1)};
            if (32'(clr_v_ff) == NUM_VERTICES - 1) begin
               clr_v_in = '0;
               clr_f_in = clr_f_ff + forest_type'(1);
               if (32'(clr_f_ff) == NUM_FORESTS - 1) begin
                  state_in = ST_IDLE;
               end
            end else begin
               clr_v_in = clr_v_ff + vertex_type'(1);
            end
         end
         ST_IDLE: begin
            status.item_ready = 1'b1;
            if (req_valid) begin
               forest_in = req_forest;
               vb_in     = req_vertex_b;
               stamp_in  = req_time_stamp;
               cur_in    = req_vertex_a;
               steps_in  = '0;
               rep_in    = req_vertex_a;
               merged_in = 1'b0;
               if (in_range) begin
                  mem_req.en   = 1'b1;
                  mem_req.addr = slot(req_forest, req_vertex_a);
                  state_in     = (req_mode == MODE_QUERY) ? ST_QUERY : ST_FIND_A;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_FIND_A: begin
            mem_req.en = 1'b1;
            if (walk_done) begin
               ra_in        = walk_end;
               cur_in       = vb_ff;
               steps_in     = '0;
               mem_req.addr = slot(forest_ff, vb_ff);
               state_in     = ST_FIND_B;
            end else begin
               cur_in       = p;
               steps_in     = step_next;
               mem_req.addr = slot(forest_ff, p);
            end
         end
         ST_FIND_B: begin
            if (walk_done) begin
               cur_in = walk_end;
               if (walk_end == ra_ff) begin
                  rep_in    = ra_ff;
                  merged_in = 1'b0;
                  state_in  = ST_DONE;
               end else begin
                  mem_req.en   = 1'b1;
                  mem_req.addr = slot(forest_ff, ra_ff);
                  state_in     = ST_SIZE_A;
               end
            end else begin
               cur_in       = p;
               steps_in     = step_next;
               mem_req.en   = 1'b1;
               mem_req.addr = slot(forest_ff, p);
            end
         end
         ST_SIZE_A: begin
            // root of a arrives now, root of b (held in cur) read next
            word_a_in    = mem_rdata;
            mem_req.en   = 1'b1;
            mem_req.addr = slot(forest_ff, cur_ff);
            state_in     = ST_SIZE_B;
         end
         ST_SIZE_B: begin
            // equal sizes put b's root under a's root
            big_in        = a_small ? cur_ff : ra_ff;
            small_in      = a_small ? ra_ff : cur_ff;
            small_size_in = small_size;
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = slot(forest_ff, a_small ? cur_ff : ra_ff);
            mem_req.wdata = '{parent: big_word.parent, stamp: big_word.stamp,
                              size: size_type'(big_word.size + small_size)};
            state_in      = ST_LINK_SMALL;
         end
         ST_LINK_SMALL: begin
            mem_req.en    = 1'b1;
            mem_req.we    = 1'b1;
            mem_req.addr  = slot(forest_ff, small_ff);
            mem_req.wdata = '{parent: big_ff, stamp: stamp_ff, size: small_size_ff};
            rep_in        = big_ff;
            merged_in     = 1'b1;
            state_in      = ST_DONE;
         end
         ST_QUERY: begin
            if (walk_done) begin
               rep_in    = walk_end;
               merged_in = 1'b0;
               state_in  = ST_DONE;
            end else begin
               cur_in       = p;
               steps_in     = step_next;
               mem_req.en   = 1'b1;
               mem_req.addr = slot(forest_ff, p);
            end
         end
         ST_DONE: begin
            result.valid = 1'b1;
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule
`default_nettype wire

[rtl/timestamped_union_find_top.sv]
// top level of the timestamped union-find block: store, sequencer and result register
//
// One disjoint-set forest per start time, kept in a single synchronous store of
// parent, link stamp and component size per vertex and forest.
// req_ channel: mode (0 union, 1 query), forest, vertex_a, vertex_b, time_stamp.
// rsp_ channel: representative and merged, one result per item, in order.
// Items are handled one at a time; every climb step is one store read.
// A query climbs from vertex_a to a root or to a link stamped past its window;
// a union climbs from both vertices to their roots and links the roots when
// they differ, the depths of both vertices being at most 10 each with union
// by size.
// The next item is taken the cycle after its predecessor's result is loaded into
// the output register, so a stalled receiver holds one result while the block
// takes and works on the following item, then waits to hand that one over.
// After reset a clearing pass writes every store entry, one per cycle, with
// req_ready low until all 65536 entries are written and the first item can be taken.
// Items naming a forest or vertex out of range return vertex_a with merged low
// and leave the store unchanged.
`default_nettype none
`include "timestamped_union_find_top_defines.svh"
module timestamped_union_find_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_mode,
   input  tuf_pkg::forest_type req_forest,
   input  tuf_pkg::vertex_type req_vertex_a,
   input  tuf_pkg::vertex_type req_vertex_b,
   input  tuf_pkg::stamp_type  req_time_stamp,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output tuf_pkg::vertex_type rsp_representative,
   output logic                rsp_merged
);
   import tuf_pkg::*;

   mem_req_type mem_req;
   entry_type   mem_rdata;
   result_type  result;
   status_type  status;
   logic        rsp_free;
   logic        rsp_valid_ff, rsp_valid_in;
   vertex_type  rsp_rep_ff, rsp_rep_in;
   logic        rsp_merged_ff, rsp_merged_in;

   tuf_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .en    (mem_req.en),
      .we    (mem_req.we),
      .addr  (mem_req.addr),
      .wdata (mem_req.wdata),
      .rdata (mem_rdata)
   );

   tuf_engine u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_mode       (req_mode),
      .req_forest     (req_forest),
      .req_vertex_a   (req_vertex_a),
      .req_vertex_b   (req_vertex_b),
      .req_time_stamp (req_time_stamp),
      .rsp_free       (rsp_free),
      .mem_rdata      (mem_rdata),
      .mem_req        (mem_req),
      .result         (result),
      .status         (status)
   );

   // output register frees up on the same cycle its result transfers
   always_comb begin
      rsp_free      = !rsp_valid_ff || rsp_ready;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_rep_in    = rsp_rep_ff;
      rsp_merged_in = rsp_merged_ff;
      if (result.valid && rsp_free) begin
         rsp_valid_in  = 1'b1;
         rsp_rep_in    = result.representative;
         rsp_merged_in = result.merged;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rep_ff    <= rsp_rep_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   assign req_ready          = status.item_ready;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_representative = rsp_rep_ff;
   assign rsp_merged         = rsp_merged_ff;

   `TUF_ASSERT_NEVER(a_no_take_while_clearing, clock, reset, status.clearing && req_ready, "item taken during clearing pass")
   `TUF_ASSERT(a_one_item_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "second item taken while busy")
   `TUF_ASSERT(a_result_held, clock, reset, result.valid && !rsp_free |=> result.valid, "pending result dropped")
   `TUF_ASSERT_NEVER(a_no_write_when_idle, clock, reset, mem_req.en && mem_req.we && req_ready, "store written while idle")
endmodule
`default_nettype wire

[verif/tb_top.sv]
// self-checking testbench for the timestamped union-find block
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tuf_pkg::*;

   typedef struct packed {
      vertex_type rep;
      logic       merged;
   } result_rec_type;

   typedef struct packed {
      logic       mode;
      forest_type forest;
      vertex_type va;
      vertex_type vb;
      stamp_type  ts;
      logic       typed;
      vertex_type rep;
      logic       merged;
   } stim_row_type;

   localparam int NUM_DIRECTED = 23;
   localparam int NUM_RANDOM   = 830;
   localparam int SETTLE_CYCLES = 60;

   // typed rows carry their expected result, the others go through the forest model
   localparam stim_row_type DIRECTED_ROWS [NUM_DIRECTED] = '{
      '{MODE_QUERY,  6'd0,  10'd0,    10'd0,    6'd0,  1'b1, 10'd0,    1'b0},
      '{MODE_QUERY,  6'd63, 10'd1023, 10'd0,    6'd63, 1'b1, 10'd1023, 1'b0},
      '{MODE_UNION,  6'd5,  10'd1,    10'd2,    6'd10, 1'b1, 10'd1,    1'b1},
      '{MODE_UNION,  6'd5,  10'd2,    10'd1,    6'd20, 1'b1, 10'd1,    1'b0},
      '{MODE_QUERY,  6'd5,  10'd2,    10'd0,    6'd9,  1'b1, 10'd2,    1'b0},
      '{MODE_QUERY,  6'd5,  10'd2,    10'd0,    6'd10, 1'b1, 10'd1,    1'b0},
      '{MODE_UNION,  6'd5,  10'd3,    10'd2,    6'd5,  1'b0, 10'd0,    1'b0},
      '{MODE_UNION,  6'd63, 10'd1023, 10'd0,    6'd63, 1'b1, 10'd1023, 1'b1},
      '{MODE_QUERY,  6'd63, 10'd0,    10'd1023, 6'd62, 1'b1, 10'd0,    1'b0},
      '{MODE_QUERY,  6'd63, 10'd0,    10'd0,    6'd63, 1'b1, 10'd1023, 1'b0},
      '{MODE_QUERY,  6'd63, 10'd1023, 10'd0,    6'd0,  1'b1, 10'd1023, 1'b0},
      '{MODE_UNION,  6'd7,  10'd4,    10'd5,    6'd30, 1'b0, 10'd0,    1'b0},
      '{MODE_UNION,  6'd7,  10'd6,    10'd7,    6'd2,  1'b0, 10'd0,    1'b0},
      '{MODE_UNION,  6'd7,  10'd4,    10'd6,    6'd1,  1'b0, 10'd0,    1'b0},
      '{MODE_QUERY,  6'd7,  10'd7,    10'd0,    6'd2,  1'b0, 10'd0,    1'b0},
      '{MODE_QUERY,  6'd7,  10'd7,    10'd0,    6'd1,  1'b0, 10'd0,    1'b0},
      '{MODE_QUERY,  6'd7,  10'd5,    10'd0,    6'd29, 1'b0, 10'd0,    1'b0},
      '{MODE_UNION,  6'd8,  10'd9,    10'd9,    6'd33, 1'b1, 10'd9,    1'b0},
      '{MODE_UNION,  6'd0,  10'd0,    10'd1023, 6'd0,  1'b1, 10'd0,    1'b1},
      '{MODE_QUERY,  6'd0,  10'd1023, 10'd555,  6'd0,  1'b1, 10'd0,    1'b0},
      '{MODE_QUERY,  6'd0,  10'd1023, 10'd0,    6'd63, 1'b0, 10'd0,    1'b0},
      '{MODE_UNION,  6'd1,  10'd682,  10'd341,  6'd63, 1'b1, 10'd682,  1'b1},
      '{MODE_QUERY,  6'd1,  10'd341,  10'd682,  6'd62, 1'b1, 10'd341,  1'b0}
   };

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_mode = MODE_UNION;
   forest_type req_forest = '0;
   vertex_type req_vertex_a = '0;
   vertex_type req_vertex_b = '0;
   stamp_type  req_time_stamp = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   vertex_type rsp_representative;
   logic       rsp_merged;

   // forest model state
   vertex_type link_parent [STORE_DEPTH];
   stamp_type  link_stamp  [STORE_DEPTH];
   size_type   comp_size   [STORE_DEPTH];

   result_rec_type awaited_results [$];
   int mismatch_count = 0;
   int result_count = 0;
   int union_count = 0;
   int join_count = 0;
   int query_count = 0;
   int deepest_climb = 0;
   int burst_left = 0;

   timestamped_union_find_top i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_forest         (req_forest),
      .req_vertex_a       (req_vertex_a),
      .req_vertex_b       (req_vertex_b),
      .req_time_stamp     (req_time_stamp),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_representative (rsp_representative),
      .rsp_merged         (rsp_merged)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic int store_index(forest_type f, vertex_type v);
      return int'(f) * NUM_VERTICES + int'(v);
   endfunction

   function automatic vertex_type find_root(forest_type f, vertex_type v);
      vertex_type cur;
      int         steps;
      cur = v;
      steps = 0;
      while (steps < NUM_VERTICES && link_parent[store_index(f, cur)] != cur) begin
         cur = link_parent[store_index(f, cur)];
         steps++;
      end
      return cur;
   endfunction

   // applies one item to the forest model and returns the result it should produce
   function automatic result_rec_type resolve_item(logic mode, forest_type f, vertex_type a,
                                                   vertex_type b, stamp_type t);
      result_rec_type r;
      vertex_type     root_a, root_b, major_root, minor_root, cur;
      int             climb;
      r.rep = a;
      r.merged = 1'b0;
      if (int'(f) >= NUM_FORESTS || int'(a) >= NUM_VERTICES) return r;
      if (mode == MODE_UNION) begin
         union_count++;
         if (int'(b) >= NUM_VERTICES) return r;
         root_a = find_root(f, a);
         root_b = find_root(f, b);
         if (root_a == root_b) begin
            r.rep = root_a;
         end else begin
            major_root = root_a;
            minor_root = root_b;
            if (comp_size[store_index(f, root_a)] < comp_size[store_index(f, root_b)]) begin
               major_root = root_b;
               minor_root = root_a;
            end
            comp_size[store_index(f, major_root)] += comp_size[store_index(f, minor_root)];
            link_parent[store_index(f, minor_root)] = major_root;
            link_stamp[store_index(f, minor_root)] = t;
            r.rep = major_root;
            r.merged = 1'b1;
            join_count++;
         end
      end else begin
         query_count++;
         cur = a;
         climb = 0;
         // stop at a root or at the first link stamped past the window
         while (climb < NUM_VERTICES && link_parent[store_index(f, cur)] != cur &&
                link_stamp[store_index(f, cur)] <= t) begin
            cur = link_parent[store_index(f, cur)];
            climb++;
         end
         r.rep = cur;
         if (climb > deepest_climb) deepest_climb = climb;
      end
      return r;
   endfunction

   task automatic flag_mismatch(string what, int got, int want);
      if (mismatch_count < 40)
         $display("%0t: result %0d: %s is %0d, expected %0d", $realtime, result_count,
                  what, got, want);
      mismatch_count++;
   endtask

   // presents one item, holds it until the transfer, then records its expected result
   task automatic send_item(logic mode, forest_type f, vertex_type a, vertex_type b,
                            stamp_type t, logic typed, vertex_type typed_rep,
                            logic typed_merged);
      int             gap;
      result_rec_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_forest     <= f;
      req_vertex_a   <= a;
      req_vertex_b   <= b;
      req_time_stamp <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = resolve_item(mode, f, a, b, t);
      if (typed) begin
         predicted.rep = typed_rep;
         predicted.merged = typed_merged;
      end
      awaited_results.insert(awaited_results.size(), predicted);
   endtask

   initial begin
      logic       mode;
      forest_type f;
      vertex_type a, b;
      int         pool_hi;
      for (int i = 0; i < STORE_DEPTH; i++) begin
         link_parent[i] = vertex_type'(i % NUM_VERTICES);
         link_stamp[i]  = stamp_type'(i / NUM_VERTICES);
         comp_size[i]   = size_type'(1);
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_ROWS[i])
         send_item(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].forest, DIRECTED_ROWS[i].va,
                   DIRECTED_ROWS[i].vb, DIRECTED_ROWS[i].ts, DIRECTED_ROWS[i].typed,
                   DIRECTED_ROWS[i].rep, DIRECTED_ROWS[i].merged);

      // most items hit a few forests over small vertex pools so the trees grow deep
      for (int i = 0; i < NUM_RANDOM; i++) begin
         mode = ($urandom_range(0, 99) < 55) ? MODE_UNION : MODE_QUERY;
         f = ($urandom_range(0, 3) == 0) ? forest_type'($urandom_range(0, 63))
                                         : forest_type'($urandom_range(0, 3));
         pool_hi = f[0] ? 63 : 15;
         a = ($urandom_range(0, 4) == 0) ? vertex_type'($urandom_range(0, 1023))
                                         : vertex_type'($urandom_range(0, pool_hi));
         b = ($urandom_range(0, 4) == 0) ? vertex_type'($urandom_range(0, 1023))
                                         : vertex_type'($urandom_range(0, pool_hi));
         send_item(mode, f, a, b, stamp_type'($urandom_range(0, 63)), 1'b0, '0, 1'b0);
      end
      req_valid <= 1'b0;

      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d unions (%0d joined two components) and %0d queries",
               union_count, join_count, query_count);
      $display("%0d results compared, deepest windowed climb %0d links",
               result_count, deepest_climb);
      if (mismatch_count == 0) begin
         $display("timestamped_union_find_top: match");
      end else begin
         $display("timestamped_union_find_top: mismatch");
      end
      $finish;
   end

   // receiver: the stall style is redrawn at random intervals
   int stall_style = 0;
   int style_left = 0;
   int hold_left = 0;

   always @(posedge clock) begin
      result_rec_type want;
      if (style_left == 0) begin
         stall_style = $urandom_range(0, 3);
         style_left = $urandom_range(50, 400);
      end else begin
         style_left--;
      end
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: begin
            if (hold_left == 0) begin
               rsp_ready <= ~rsp_ready;
               hold_left = $urandom_range(0, 15);
            end else begin
               hold_left--;
            end
         end
      endcase

      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            flag_mismatch("unexpected transfer, representative", rsp_representative, -1);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_representative !== want.rep)
               flag_mismatch("representative", rsp_representative, want.rep);
            if (rsp_merged !== want.merged)
               flag_mismatch("merged", rsp_merged, want.merged);
         end
         result_count++;
      end
   end

   initial begin
      #8ms;
      $display("timeout with %0d results outstanding", awaited_results.size());
      $display("timestamped_union_find_top: mismatch");
      $finish;
   end
endmodule
